@@ rtl/core/bra_pkg.sv @@
// Package for the bitmap run allocator.
// Holds op codes, status codes, register indexes, the controller states and the scan result type.
// No dependencies.
package bra_pkg;

    localparam int IDX_W   = 32;
    localparam int RUN_W   = 13;
    localparam int START_W = 12;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 32;
    localparam int USED_W  = 10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_TEST  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SCAN  = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_RUN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    localparam logic CFG_INDEX_OFFSET = 1'b0;
    localparam logic CFG_USED_BYTES   = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_TEST,
        ST_WRITE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [RUN_W-1:0]   run;
        logic [START_W-1:0] start;
    } t_scan_res;

endpackage

@@ rtl/core/bra_mem.sv @@
// Allocation map storage: one byte per entry, one write and one read port.
// Read data is registered. Uses no package.
module bra_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bra_scan.sv @@
// Free-run counter for one map byte: walks its eight bits from bit 0 up.
// Depends on bra_pkg for widths and the scan result type.
module bra_scan #(
    parameter int AW = 9
) (
    input  logic [7:0]                   i_byte,
    input  logic [AW-1:0]                i_addr,
    input  logic [bra_pkg::RUN_W-1:0]    i_count,
    input  logic [bra_pkg::RUN_W-1:0]    i_run,
    input  logic [bra_pkg::START_W-1:0]  i_start,
    output bra_pkg::t_scan_res           o_res
);
    import bra_pkg::*;

    always_comb begin
        logic [AW+3:0] pos;
        o_res.hit   = 1'b0;
        o_res.run   = i_run;
        o_res.start = i_start;
        for (int b = 0; b < 8; b++) begin
            pos = {1'b0, i_addr, 3'(b)};
            if (!o_res.hit) begin
                if (i_byte[b]) begin
                    o_res.run   = '0;
                    o_res.start = START_W'(pos + 1'b1);
                end else begin
                    o_res.run = o_res.run + 1'b1;
                    if (o_res.run == i_count) begin
                        o_res.hit = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/core/bitmap_run_allocator_top.sv @@
// Bitmap run allocator: a map of MAP_BYTES bytes, one bit per unit, one = allocated. One
// transaction in flight at a time; the result sits in an output register so the next
// transaction can be taken while it waits. The single byte-wide map memory sets the pace, one
// byte read or written per cycle: test reads the map byte, write reads it and writes it back,
// a test or write out of range goes straight to its result, clear writes each byte in use,
// and scan reads the bytes in use in turn until the run is found. A result that finds the
// output register still full holds the block until the output drains. After reset a clearing
// pass writes all MAP_BYTES entries, one per cycle, before the first transaction is accepted.
module bitmap_run_allocator_top #(
    parameter int MAP_BYTES = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [bra_pkg::IDX_W-1:0]    i_index,
    input  logic                         i_set_value,
    input  logic [bra_pkg::RUN_W-1:0]    i_run_length,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_bit_value,
    output logic [bra_pkg::START_W-1:0]  o_start_index,
    output logic [bra_pkg::STAT_W-1:0]   o_status,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [bra_pkg::CFG_W-1:0]    i_cfg_data
);
    import bra_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = $clog2(MAP_BYTES + 1);
    localparam int LW = (CW > USED_W) ? CW : USED_W;

    t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [IDX_W-1:0] r_index_offset;
    logic [LW-1:0] r_used_bytes;

    logic [AW-1:0] r_byte;
    logic [2:0] r_bit;
    logic r_setv;
    logic [RUN_W-1:0] r_count;
    logic [RUN_W-1:0] r_run;
    logic [START_W-1:0] r_rstart;
    logic r_res_bit;
    logic [START_W-1:0] r_res_start;
    logic [STAT_W-1:0] r_res_status;
    logic r_out_valid;
    logic r_out_bit;
    logic [START_W-1:0] r_out_start;
    logic [STAT_W-1:0] r_out_status;

    logic [LW-1:0] w_live;
    logic [IDX_W-1:0] w_rel;
    logic w_test_range, w_write_range, w_range;
    logic w_accept, w_out_free, w_init_last, w_live_last;
    t_op w_op;
    logic w_mem_we, w_mem_re;
    logic [AW-1:0] w_mem_waddr, w_mem_raddr;
    logic [7:0] w_mem_wdata, w_mem_rdata, w_mask;
    t_scan_res w_scan;

    always_comb begin
        if (r_used_bytes == '0) begin
            w_live = LW'(1);
        end else if (r_used_bytes > LW'(MAP_BYTES)) begin
            w_live = LW'(MAP_BYTES);
        end else begin
            w_live = r_used_bytes;
        end
    end

    assign w_op          = t_op'(i_op);
    assign w_rel         = i_index - r_index_offset;
    assign w_test_range  = (i_index < r_index_offset) ||
                           ({3'b000, w_rel[IDX_W-1:3]} >= IDX_W'(w_live));
    assign w_write_range = {3'b000, i_index[IDX_W-1:3]} >= IDX_W'(w_live);
    assign w_range       = (w_op == OP_TEST) ? w_test_range :
                           (w_op == OP_WRITE) ? w_write_range : 1'b0;
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_init_last   = r_addr == AW'(MAP_BYTES - 1);
    assign w_live_last   = (LW'(r_addr) + LW'(1)) == w_live;
    assign w_mask        = 8'(1) << r_bit;

    bra_mem #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bra_scan #(
        .AW (AW)
    ) u_scan (
        .i_byte  (w_mem_rdata),
        .i_addr  (r_addr),
        .i_count (r_count),
        .i_run   (r_run),
        .i_start (r_rstart),
        .o_res   (w_scan)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_init_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_TEST:  n_state = w_test_range ? ST_RESP : ST_TEST;
                        OP_WRITE: n_state = w_write_range ? ST_RESP : ST_WRITE;
                        OP_SCAN:  n_state = ST_SCAN;
                        default:  n_state = ST_RESP;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (w_live_last) n_state = ST_RESP;
            end
            ST_TEST, ST_WRITE: begin
                n_state = ST_RESP;
            end
            ST_SCAN: begin
                if (w_scan.hit || w_live_last) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = '0;
        n_addr      = r_addr;
        case (r_state)
            ST_INIT: begin
                w_mem_we = 1'b1;
                n_addr   = r_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_mem_re   = i_in_valid;
                n_addr     = i_in_valid ? '0 : r_addr;
                case (w_op)
                    OP_TEST:  w_mem_raddr = w_rel[AW+2:3];
                    OP_WRITE: w_mem_raddr = i_index[AW+2:3];
                    default:  w_mem_raddr = '0;
                endcase
            end
            ST_CLEAR: begin
                w_mem_we = 1'b1;
                n_addr   = r_addr + 1'b1;
            end
            ST_WRITE: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_byte;
                w_mem_wdata = r_setv ? (w_mem_rdata | w_mask) : (w_mem_rdata & ~w_mask);
            end
            ST_SCAN: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_addr + 1'b1;
                n_addr      = r_addr + 1'b1;
            end
            default: begin
                n_addr = r_addr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_INIT;
            r_addr         <= '0;
            r_out_valid    <= 1'b0;
            r_index_offset <= '0;
            r_used_bytes   <= LW'(MAP_BYTES);
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (r_state == ST_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INDEX_OFFSET: r_index_offset <= i_cfg_data;
                    CFG_USED_BYTES:   r_used_bytes   <= LW'(i_cfg_data[USED_W-1:0]);
                    default:          r_index_offset <= r_index_offset;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte       <= (w_op == OP_TEST) ? w_rel[AW+2:3] : i_index[AW+2:3];
            r_bit        <= (w_op == OP_TEST) ? w_rel[2:0] : i_index[2:0];
            r_setv       <= i_set_value;
            r_count      <= (i_run_length == '0) ? RUN_W'(1) : i_run_length;
            r_run        <= '0;
            r_rstart     <= '0;
            r_res_bit    <= 1'b0;
            r_res_start  <= '0;
            r_res_status <= w_range ? STAT_RANGE : STAT_OK;
        end
        if (r_state == ST_TEST) begin
            r_res_bit <= w_mem_rdata[r_bit];
        end
        if (r_state == ST_SCAN) begin
            r_run    <= w_scan.run;
            r_rstart <= w_scan.start;
            if (w_scan.hit) begin
                r_res_start <= w_scan.start;
            end else if (w_live_last) begin
                r_res_status <= STAT_NO_RUN;
                r_res_start  <= '0;
            end
        end
        if (r_state == ST_RESP && w_out_free) begin
            r_out_bit    <= r_res_bit;
            r_out_start  <= r_res_start;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bit_value   = r_out_bit;
    assign o_start_index = r_out_start;
    assign o_status      = r_out_status;

`ifndef SYNTHESIS
    a_scan_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (LW'(r_addr) < w_live))
        else $error("scan address past the bytes in use");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_mem_we)
        else $error("transaction accepted while the map is being written");

    a_no_run_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STAT_NO_RUN) |-> (r_out_start == '0))
        else $error("failed scan reports a nonzero start");

    a_bit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bit) |-> (r_out_status == STAT_OK))
        else $error("tested bit set on a failed transaction");
`endif

endmodule

@@ tb/tb_bitmap_run_allocator_top.sv @@
`timescale 1ns / 1ps
// Testbench for bitmap_run_allocator_top: clear, test, write and free-run scan transactions
// checked against a shadow copy of the allocation map. Depends on bra_pkg and the top level.
module tb_bitmap_run_allocator_top;
    import bra_pkg::*;

    localparam int MAP_BYTES      = 512;
    localparam int MAP_AW         = $clog2(MAP_BYTES);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic             set_value;
        logic [RUN_W-1:0] run_length;
    } t_alloc_req;

    typedef struct packed {
        logic               bit_value;
        logic [START_W-1:0] start_index;
        logic [STAT_W-1:0]  status;
    } t_alloc_reply;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_op         = OP_CLEAR;
    logic [IDX_W-1:0]     i_index      = '0;
    logic                 i_set_value  = 1'b0;
    logic [RUN_W-1:0]     i_run_length = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_bit_value;
    logic [START_W-1:0]   o_start_index;
    logic [STAT_W-1:0]    o_status;
    logic                 i_cfg_we     = 1'b0;
    logic                 i_cfg_index  = CFG_INDEX_OFFSET;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    t_alloc_req   request_q[$];
    t_alloc_reply reply_q[$];

    logic [7:0]        shadow_map [MAP_BYTES];
    logic [31:0]       shadow_offset = '0;
    logic [USED_W-1:0] shadow_used   = USED_W'(MAP_BYTES);

    bit quiet_io      = 1'b0;
    int mismatches    = 0;
    int send_gap      = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    bitmap_run_allocator_top #(.MAP_BYTES(MAP_BYTES)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_set_value  (i_set_value),
        .i_run_length (i_run_length),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_bit_value  (o_bit_value),
        .o_start_index(o_start_index),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned live_bytes(input logic [USED_W-1:0] used);
        int unsigned u;
        u = 32'(used);
        if (u < 1) u = 1;
        if (u > MAP_BYTES) u = MAP_BYTES;
        return u;
    endfunction

    task automatic apply_alloc_op(input t_alloc_req rq, output t_alloc_reply rp);
        int unsigned bytes;
        int unsigned total;
        int unsigned want;
        int unsigned free_len;
        int unsigned pos;
        logic [31:0] rel;
        bit found;
        rp = '0;
        bytes = live_bytes(shadow_used);
        total = bytes * 8;
        case (rq.op)
            OP_CLEAR: begin
                for (int b = 0; b < bytes; b++) shadow_map[b[MAP_AW-1:0]] = '0;
            end
            OP_TEST: begin
                if (rq.index < shadow_offset) begin
                    rp.status = STAT_RANGE;
                end else begin
                    rel = rq.index - shadow_offset;
                    if ((rel >> 3) >= bytes) rp.status = STAT_RANGE;
                    else rp.bit_value = shadow_map[rel[MAP_AW+2:3]][rel[2:0]];
                end
            end
            OP_WRITE: begin
                if ((rq.index >> 3) >= bytes) rp.status = STAT_RANGE;
                else shadow_map[rq.index[MAP_AW+2:3]][rq.index[2:0]] = rq.set_value;
            end
            default: begin
                want = (rq.run_length == 0) ? 1 : rq.run_length;
                free_len = 0;
                found = 1'b0;
                for (pos = 0; pos < total && !found; pos++) begin
                    if (shadow_map[pos[MAP_AW+2:3]][pos[2:0]] == 1'b0) free_len++;
                    else free_len = 0;
                    if (free_len == want) begin
                        rp.start_index = START_W'(pos + 1 - want);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rp.status = STAT_NO_RUN;
                    rp.start_index = '0;
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_bit(input int unsigned bits);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, bits - 1);
        if (r < 90) return $urandom_range(bits - 1, bits);
        return $urandom;
    endfunction

    function automatic logic [RUN_W-1:0] pick_run(input int unsigned bits);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return RUN_W'($urandom_range(1, 12));
        if (r < 80) return RUN_W'($urandom_range(1, bits));
        if (r < 90) return RUN_W'($urandom_range(1, 4096));
        return RUN_W'($urandom_range(0, 8191));
    endfunction

    task automatic push_req(input t_op op, input logic [31:0] index, input logic set_value,
                            input logic [RUN_W-1:0] run_length);
        t_alloc_req rq;
        rq.op = op;
        rq.index = index;
        rq.set_value = set_value;
        rq.run_length = run_length;
        request_q.push_back(rq);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_INDEX_OFFSET) shadow_offset = data;
        else shadow_used = data[USED_W-1:0];
    endtask

    task automatic fill_random(input int n);
        int unsigned bits;
        int unsigned k;
        int r;
        int made;
        logic [31:0] s;
        logic v;
        made = 0;
        bits = live_bytes(shadow_used) * 8;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // allocate or free a short run of neighboring bits
                s = pick_bit(bits);
                k = $urandom_range(1, 8);
                v = ($urandom_range(0, 3) != 0);
                for (int j = 0; j < k; j++)
                    push_req(OP_WRITE, s + j, v, RUN_W'($urandom_range(0, 8191)));
                made += k;
            end else if (r < 52) begin
                push_req(OP_SCAN, $urandom, 1'($urandom_range(0, 1)), pick_run(bits));
                made++;
            end else if (r < 76) begin
                if ($urandom_range(0, 9) == 0) s = $urandom;
                else s = shadow_offset + pick_bit(bits);
                push_req(OP_TEST, s, 1'($urandom_range(0, 1)),
                         RUN_W'($urandom_range(0, 8191)));
                made++;
            end else if (r < 90) begin
                push_req(OP_WRITE, pick_bit(bits), 1'($urandom_range(0, 1)),
                         RUN_W'($urandom_range(0, 8191)));
                made++;
            end else if (r < 93) begin
                push_req(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                         RUN_W'($urandom_range(0, 8191)));
                made++;
            end else begin
                push_req(t_op'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                         RUN_W'($urandom_range(0, 8191)));
                made++;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_alloc_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                nxt = request_q.pop_front();
                i_op         <= nxt.op;
                i_index      <= nxt.index;
                i_set_value  <= nxt.set_value;
                i_run_length <= nxt.run_length;
                i_in_valid   <= 1'b1;
                send_gap = quiet_io ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet_io) hold_left = pick_gap();
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_alloc_req rq;
        t_alloc_reply rp;
        t_alloc_reply want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    note_mismatch("result with no transaction outstanding", 32'(o_status), 0);
                end else begin
                    want = reply_q.pop_front();
                    if (o_bit_value !== want.bit_value)
                        note_mismatch("bit_value", 32'(o_bit_value), 32'(want.bit_value));
                    if (o_start_index !== want.start_index)
                        note_mismatch("start_index", 32'(o_start_index),
                                      32'(want.start_index));
                    if (o_status !== want.status)
                        note_mismatch("status", 32'(o_status), 32'(want.status));
                end
            end
            if (i_in_valid && o_in_ready) begin
                rq.op = t_op'(i_op);
                rq.index = i_index;
                rq.set_value = i_set_value;
                rq.run_length = i_run_length;
                apply_alloc_op(rq, rp);
                reply_q.push_back(rp);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] offset;
        logic [31:0] used;
        for (int b = 0; b < MAP_BYTES; b++) shadow_map[b[MAP_AW-1:0]] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full map at reset settings: edges, boundary writes, long scans
        push_req(OP_SCAN, 0, 0, 1);
        push_req(OP_WRITE, 0, 1, 0);
        push_req(OP_WRITE, 4095, 1, 0);
        push_req(OP_WRITE, 800, 1, 0);
        push_req(OP_WRITE, 4096, 1, 0);
        push_req(OP_WRITE, 32'hFFFF_FFFF, 1, 13'h1FFF);
        push_req(OP_TEST, 0, 0, 0);
        push_req(OP_TEST, 4095, 1, 0);
        push_req(OP_TEST, 4096, 0, 0);
        push_req(OP_TEST, 32'hFFFF_FFFF, 0, 0);
        push_req(OP_SCAN, 0, 0, 0);
        push_req(OP_SCAN, 0, 0, 4094);
        push_req(OP_SCAN, 0, 0, 4095);
        push_req(OP_SCAN, 32'hFFFF_FFFF, 1, 13'h1FFF);

        // two bytes in use, offset tests, partial clear
        wait_drained();
        write_reg(CFG_INDEX_OFFSET, 100);
        write_reg(CFG_USED_BYTES, 2);
        push_req(OP_TEST, 99, 0, 0);
        push_req(OP_TEST, 100, 0, 0);
        push_req(OP_TEST, 115, 0, 0);
        push_req(OP_TEST, 116, 0, 0);
        push_req(OP_WRITE, 16, 1, 0);
        push_req(OP_CLEAR, 0, 0, 0);
        push_req(OP_SCAN, 0, 0, 16);

        // used_bytes wraps to zero in ten bits, offset at its top
        wait_drained();
        write_reg(CFG_INDEX_OFFSET, 32'hFFFF_FFFF);
        write_reg(CFG_USED_BYTES, 32'h0000_0400);
        push_req(OP_WRITE, 7, 1, 0);
        push_req(OP_WRITE, 8, 1, 0);
        push_req(OP_TEST, 32'hFFFF_FFFF, 0, 0);
        push_req(OP_TEST, 0, 0, 0);

        // oversized used_bytes, bytes past the earlier clear keep their bits
        wait_drained();
        write_reg(CFG_INDEX_OFFSET, 0);
        write_reg(CFG_USED_BYTES, 1023);
        push_req(OP_TEST, 800, 0, 0);
        push_req(OP_SCAN, 0, 0, 4096);

        for (int p = 0; p < 14; p++) begin
            case (p)
                0: used = 1;
                1: used = 512;
                2: used = 0;
                3: used = 1023;
                default: begin
                    if ($urandom_range(0, 9) == 0) used = $urandom_range(17, 512);
                    else used = $urandom_range(1, 16);
                end
            endcase
            case (p % 4)
                0: offset = 0;
                1: offset = 32'hFFFF_FFFF;
                2: offset = $urandom;
                default: offset = $urandom_range(0, 64);
            endcase
            // hold off until the block has returned every result
            wait_drained();
            write_reg(CFG_INDEX_OFFSET, offset);
            write_reg(CFG_USED_BYTES, used);
            quiet_io = (p % 5 == 2);
            fill_random(125);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule
